/* rtl/core/pcg32rr_pkg.sv */
`timescale 1ns / 1ps

package pcg32rr_pkg;

	// LCG multiplier of the PCG32 generator.
	localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;

	// XSH-RR output shifts.
	localparam int unsigned XSH_SHIFT = 18;
	localparam int unsigned OUT_SHIFT = 27;
	localparam int unsigned ROT_SHIFT = 59;

	// Status of the remainder unit as seen by the sequencer.
	typedef struct packed {
		logic done;
	} div_status_t;

	// XSH-RR permutation of the state before its advance.
	function automatic logic [31:0] pcg_output(input logic [63:0] s);
		logic [63:0] mixed;
		logic [31:0] xs;
		logic [4:0]  rot;
		logic [63:0] doubled;
		begin
			mixed   = (s >> XSH_SHIFT) ^ s;
			xs      = mixed[OUT_SHIFT +: 32];
			rot     = s[ROT_SHIFT +: 5];
			doubled = {xs, xs} >> rot;
			pcg_output = doubled[31:0];
		end
	endfunction

endpackage

/* rtl/core/pcg32_ranged_random_generator.sv */
`timescale 1ns / 1ps

// PCG32 (XSH-RR) generator with a signed ranged output. Each input transaction
// carries range_low and range_high and yields one output transaction with the raw
// 32-bit word and range_low + raw mod span, where span = range_high - range_low + 1
// modulo 2^32 and a zero span means the full range. Writing the seed reloads the
// state and sets the increment to seed * 2 + 1. For each item the 64-bit state
// advance runs as three 32 by 32 products through one shared multiplier, then the
// modulo runs in a one-bit-per-cycle remainder unit; a zero span skips the modulo.
// The input is stalled while an item is in work; a finished result waits in the
// output register while the next item is accepted.
module pcg32_ranged_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] raw_word,
	output logic [31:0] ranged_value
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  mcnt_q;
	logic [62:0] seed_q;
	logic [63:0] lcg_q;
	logic [63:0] acc_q;
	logic [31:0] raw_q;
	logic [31:0] low_q;
	logic [31:0] span_q;
	logic [31:0] off_q;
	logic        out_valid_q;
	logic [31:0] raw_word_q;
	logic [31:0] ranged_q;

	logic        in_acc;
	logic        out_free;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] product;
	logic        div_start;
	logic [31:0] remainder;
	logic [63:0] increment;
	pcg32rr_pkg::div_status_t div_status;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign increment = {seed_q, 1'b1};
	assign div_start = (state_q == ST_MUL) && (mcnt_q == 2'd3) && (span_q != 32'd0);

	// Operand selection for the three partial products of the low 64 bits.
	always_comb begin
		case (mcnt_q)
			2'd0: begin
				mul_a = lcg_q[31:0];
				mul_b = pcg32rr_pkg::PCG_MULT[31:0];
			end
			2'd1: begin
				mul_a = lcg_q[31:0];
				mul_b = pcg32rr_pkg::PCG_MULT[63:32];
			end
			2'd2: begin
				mul_a = lcg_q[63:32];
				mul_b = pcg32rr_pkg::PCG_MULT[31:0];
			end
			default: begin
				mul_a = lcg_q[31:0];
				mul_b = pcg32rr_pkg::PCG_MULT[31:0];
			end
		endcase
	end

	pcg32rr_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (product)
	);

	pcg32rr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (raw_q),
		.divisor   (span_q),
		.status    (div_status),
		.remainder (remainder)
	);

	// Sequencer, seed register and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mcnt_q      <= '0;
			seed_q      <= '0;
			lcg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register is freed here unless a new result replaces it.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (seed_we) begin
						seed_q <= seed_data[62:0];
						lcg_q  <= seed_data;
					end
					if (in_acc) begin
						mcnt_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						lcg_q <= acc_q + {product[31:0], 32'd0};
						if (span_q != 32'd0) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item datapath: captured operands, state accumulator, offset and output register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q  <= pcg32rr_pkg::pcg_output(lcg_q);
			low_q  <= range_low;
			span_q <= range_high - range_low + 32'd1;
		end
		if (state_q == ST_MUL) begin
			if (mcnt_q == 2'd1) begin
				acc_q <= product + increment;
			end else if (mcnt_q == 2'd2) begin
				acc_q <= acc_q + {product[31:0], 32'd0};
			end
			if (mcnt_q == 2'd3 && span_q == 32'd0) begin
				off_q <= raw_q;
			end
		end
		if (state_q == ST_DIV && div_status.done) begin
			off_q <= remainder;
		end
		if (state_q == ST_DONE && out_free) begin
			raw_word_q <= raw_q;
			ranged_q   <= low_q + off_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign raw_word     = raw_word_q;
	assign ranged_value = ranged_q;

endmodule

/* rtl/core/pcg32rr_mul.sv */
`timescale 1ns / 1ps

// Shared 32 by 32 multiplier with a registered product.
module pcg32rr_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] product
);

	logic [63:0] product_q;

	// The product is registered every cycle; the sequencer picks the cycle it needs.
	always_ff @(posedge clk) begin
		product_q <= 64'(op_a) * 64'(op_b);
	end

	assign product = product_q;

endmodule

/* rtl/core/pcg32rr_div.sv */
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle over the 32-bit dividend.
module pcg32rr_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              dividend,
	input  logic [31:0]              divisor,
	output pcg32rr_pkg::div_status_t status,
	output logic [31:0]              remainder
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// One restoring step: shift in the next dividend bit and subtract when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		diff  = trial - {1'b0, dvs_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff[31:0];
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

/* tb/sv/pcg32_ranged_random_generator_test.sv */
`timescale 1ns / 1ps

module pcg32_ranged_random_generator_test;

	localparam logic [63:0] LCG_MULTIPLIER = 64'd6364136223846793005;
	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned RANDOM_DRAWS   = 630;
	localparam int unsigned SETTLE_CYCLES  = 50;

	// One expected output transaction.
	typedef struct {
		logic [31:0] raw;
		logic [31:0] ranged;
	} draw_t;

	typedef enum logic {ROW_REQUEST, ROW_SEED} row_kind_t;

	// One row of the directed table; known values are filled in only where obvious.
	typedef struct {
		row_kind_t   kind;
		logic [63:0] seed;
		logic [31:0] lo;
		logic [31:0] hi;
		bit          known;
		logic [31:0] raw;
		logic [31:0] ranged;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        seed_we;
	logic [63:0] seed_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] range_low;
	logic [31:0] range_high;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] raw_word;
	logic [31:0] ranged_value;

	// Generator state as the testbench tracks it.
	logic [63:0] lcg_state_model;
	logic [63:0] seed_model;

	draw_t       pending_draws[$];
	step_t       directed_steps[$];

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned draws_sent;
	int unsigned seed_loads;

	pcg32_ranged_random_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_we      (seed_we),
		.seed_data    (seed_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_low    (range_low),
		.range_high   (range_high),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.raw_word     (raw_word),
		.ranged_value (ranged_value)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending", cycle_count,
				pending_draws.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Advances the tracked LCG state and returns the XSH-RR word of the old state.
	function automatic logic [31:0] pcg_draw_next();
		logic [63:0] prior;
		logic [63:0] mixed;
		logic [31:0] xs;
		int unsigned rot;
		prior = lcg_state_model;
		lcg_state_model = prior * LCG_MULTIPLIER + {seed_model[62:0], 1'b1};
		mixed = (prior >> 18) ^ prior;
		xs = mixed[58:27];
		rot = prior[63:59];
		return (xs >> rot) | (xs << ((32 - rot) & 31));
	endfunction

	// Maps a raw word into the range; a zero span means the full 32-bit range.
	function automatic logic [31:0] ranged_of(logic [31:0] lo, logic [31:0] hi,
		logic [31:0] raw);
		logic [31:0] span;
		logic [31:0] offset;
		span = hi - lo + 32'd1;
		offset = (span != 32'd0) ? raw % span : raw;
		return lo + offset;
	endfunction

	function automatic step_t req(int lo, int hi);
		return '{ROW_REQUEST, 64'd0, lo, hi, 1'b0, 32'd0, 32'd0};
	endfunction

	function automatic step_t req_known(int lo, int hi, logic [31:0] raw,
		logic [31:0] ranged);
		return '{ROW_REQUEST, 64'd0, lo, hi, 1'b1, raw, ranged};
	endfunction

	function automatic step_t seed_row(logic [63:0] value);
		return '{ROW_SEED, value, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("Mismatch at cycle %0d: %s is %h, expected %h", cycle_count, what, got,
			want);
		mismatch_count++;
	endtask

	// Offers one range request and records its expected result once accepted.
	task automatic issue_range(logic [31:0] lo, logic [31:0] hi, bit known,
		logic [31:0] known_raw, logic [31:0] known_ranged);
		draw_t want;
		logic [31:0] raw;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		range_low <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (in_stall);
		raw = pcg_draw_next();
		if (known) begin
			want.raw = known_raw;
			want.ranged = known_ranged;
		end else begin
			want.raw = raw;
			want.ranged = ranged_of(lo, hi, raw);
		end
		pending_draws.push_back(want);
		draws_sent++;
	endtask

	// Stops offering requests until every pending result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
	endtask

	// Loads a new seed while the block is idle.
	task automatic load_seed(logic [63:0] value);
		drain_results();
		seed_we <= 1'b1;
		seed_data <= value;
		@(posedge clk);
		seed_we <= 1'b0;
		seed_model = value;
		lcg_state_model = value;
		seed_loads++;
	endtask

	// Picks a random range, mostly narrow, with the wrapping cases mixed in.
	task automatic random_range(output logic [31:0] lo, output logic [31:0] hi);
		int unsigned pick;
		lo = $urandom();
		pick = $urandom_range(9);
		case (pick) inside
			[0:3]: begin
				hi = lo + $urandom_range(1000);
			end
			4: begin
				hi = $urandom();
			end
			5: begin
				// Full range: the span wraps to zero.
				hi = lo - 32'd1;
			end
			6: begin
				hi = lo;
			end
			7: begin
				hi = lo + (32'd1 << $urandom_range(31)) - 32'd1;
			end
			8: begin
				// Backwards range: a huge unsigned span.
				hi = lo - $urandom_range(1000, 2);
			end
			default: begin
				lo = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				hi = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
		endcase
	endtask

	// Receiver side: random stall, sampled at the edge like everything else.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Compares each accepted output transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("unexpected raw_word", raw_word, 32'd0);
			end else begin
				want = pending_draws.pop_front();
				if (raw_word !== want.raw)
					report_mismatch("raw_word", raw_word, want.raw);
				if (ranged_value !== want.ranged)
					report_mismatch("ranged_value", ranged_value, want.ranged);
				results_checked++;
			end
		end
	end

	initial begin
		logic [31:0] lo;
		logic [31:0] hi;
		int unsigned directed_count;

		arst_n = 1'b0;
		seed_we = 1'b0;
		seed_data = 64'd0;
		in_valid = 1'b0;
		range_low = 32'd0;
		range_high = 32'd0;
		draws_sent = 0;
		seed_loads = 0;
		sender_idle_pct = 22;
		receiver_stall_pct = 47;
		seed_model = 64'd0;
		lcg_state_model = 64'd0;

		// Directed table. State 0 and state 1 both give a raw word of zero.
		directed_steps.push_back(req_known(-5, 5, 32'd0, -32'sd5));
		directed_steps.push_back(req_known(100, 200, 32'd0, 32'd100));
		directed_steps.push_back(req(32'h8000_0000, 32'h7FFF_FFFF));
		directed_steps.push_back(req(0, 0));
		directed_steps.push_back(req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		directed_steps.push_back(req(32'h8000_0000, 32'h8000_0000));
		directed_steps.push_back(req(10, -10));
		directed_steps.push_back(req(32'h7FFF_FFFF, 32'h8000_0000));
		directed_steps.push_back(req(0, -1));
		directed_steps.push_back(req(-1, 0));
		directed_steps.push_back(req(0, 32'h7FFF_FFFE));
		directed_steps.push_back(req(-1, -2));
		// An all-ones state gives the word FFF00001; the full range passes it through.
		directed_steps.push_back(seed_row(64'hFFFF_FFFF_FFFF_FFFF));
		directed_steps.push_back(req_known(0, -1, 32'hFFF0_0001, 32'hFFF0_0001));
		directed_steps.push_back(req(1, -1));
		directed_steps.push_back(seed_row(64'd0));
		directed_steps.push_back(req_known(7, 9, 32'd0, 32'd7));
		directed_steps.push_back(req_known(7, 9, 32'd0, 32'd7));
		directed_steps.push_back(seed_row(64'h8000_0000_0000_0000));
		directed_steps.push_back(req(-100, 100));
		directed_steps.push_back(req(32'h8000_0000, -1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == ROW_SEED)
				load_seed(directed_steps[i].seed);
			else
				issue_range(directed_steps[i].lo, directed_steps[i].hi,
					directed_steps[i].known, directed_steps[i].raw,
					directed_steps[i].ranged);
		end
		directed_count = draws_sent;

		// Random phases: receiver stalls most, then sender idles most, then full speed.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 22;
					receiver_stall_pct = 47;
					load_seed({$urandom(), $urandom()});
				end
				1: begin
					sender_idle_pct = 47;
					receiver_stall_pct = 22;
					load_seed(64'd1);
				end
				default: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					load_seed({$urandom(), $urandom()});
				end
			endcase
			for (int n = 0; n < RANDOM_DRAWS; n++) begin
				if ($urandom_range(149) == 0)
					drain_results();
				random_range(lo, hi);
				issue_range(lo, hi, 1'b0, 32'd0, 32'd0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d directed and %0d random draws over %0d seed loads,",
			directed_count, draws_sent - directed_count, seed_loads);
		$display("with idle sender, stalling receiver and full-rate phases; %0d results checked.",
			results_checked);
		if (mismatch_count == 0 && pending_draws.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatch_count,
				pending_draws.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
